// File: src/sme_pkg.sv
// ----------------------------------------------------------------------------
// sme_pkg
// Shared types and constants for the byte-serial stack machine executor.
// ----------------------------------------------------------------------------
package sme_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int WORD_W      = 32;
    localparam int RES_DEPTH_W = 9;
    localparam int IMM_LEFT_W  = 3;
    localparam int IMM_BYTES   = 4;

    typedef enum logic [7:0] {
        OP_NOP   = 8'd0,
        OP_PUSH  = 8'd1,
        OP_DUP   = 8'd2,
        OP_DROP  = 8'd3,
        OP_SWAP  = 8'd4,
        OP_ADD   = 8'd5,
        OP_PRINT = 8'd6,
        OP_HALT  = 8'd7
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_PRINT = 2'd0,
        KIND_HALT  = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_OVERFLOW  = 3'd1,
        ERR_UNDERFLOW = 3'd2,
        ERR_PAST_END  = 3'd3,
        ERR_SHORT_IMM = 3'd4,
        ERR_UNKNOWN   = 3'd5
    } err_t;

    typedef struct packed {
        kind_t                    kind;
        logic signed [WORD_W-1:0] value;
        err_t                     err;
        logic [RES_DEPTH_W-1:0]   depth;
    } result_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [WORD_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } ram_req_t;

    function automatic logic [RES_DEPTH_W-1:0] depth_field(input logic [DEPTH_W-1:0] d);
        logic [DEPTH_W+RES_DEPTH_W-1:0] wide;
        wide = {{RES_DEPTH_W{1'b0}}, d};
        return wide[RES_DEPTH_W-1:0];
    endfunction

endpackage

// File: src/sme_if.sv
// ----------------------------------------------------------------------------
// sme_if
// Valid/ready channels for instruction bytes and results.
// ----------------------------------------------------------------------------
interface sme_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic       program_start;
    logic       program_end;

    modport source (output valid, output code_byte, output program_start,
                    output program_end, input ready);
    modport sink   (input valid, input code_byte, input program_start,
                    input program_end, output ready);
endinterface

interface sme_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         result_kind;
    logic signed [31:0] printed_value;
    logic [2:0]         error_code;
    logic [8:0]         stack_depth;

    modport source (output valid, output result_kind, output printed_value,
                    output error_code, output stack_depth, input ready);
    modport sink   (input valid, input result_kind, input printed_value,
                    input error_code, input stack_depth, output ready);
endinterface

// File: src/sme_ram.sv
// ----------------------------------------------------------------------------
// sme_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/sme_core.sv
// ----------------------------------------------------------------------------
// sme_core
// Decode and execute, with the top three stack entries cached in front of
// the stack RAM.
// ----------------------------------------------------------------------------
module sme_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic [7:0]                   code_byte,
    input  logic                         program_start,
    input  logic                         program_end,
    input  logic [sme_pkg::WORD_W-1:0]   ram_rdata,
    output sme_pkg::ram_req_t            ram_req,
    output logic                         res_valid,
    output sme_pkg::result_t             res
);

    logic [sme_pkg::DEPTH_W-1:0]    depth_reg, depth_next;
    logic                           stopped_reg, stopped_next;
    logic [sme_pkg::IMM_LEFT_W-1:0] left_reg, left_next;
    logic [sme_pkg::WORD_W-1:0]     gather_reg, gather_next;
    logic [sme_pkg::WORD_W-1:0]     tos_reg, tos_next;
    logic [sme_pkg::WORD_W-1:0]     nos_reg, nos_next;
    logic [sme_pkg::WORD_W-1:0]     third_reg, third_next;
    logic                           pend_reg, pend_next;

    logic [sme_pkg::DEPTH_W-1:0]    d;
    logic [sme_pkg::IMM_LEFT_W-1:0] left;
    logic [sme_pkg::IMM_LEFT_W-1:0] left_dec;
    logic [sme_pkg::WORD_W-1:0]     gat;
    logic [sme_pkg::WORD_W-1:0]     gat_new;
    logic [sme_pkg::WORD_W-1:0]     third_eff;
    logic [4:0]                     shamt;
    logic                           full;
    logic                           do_push;
    logic                           do_pop;
    logic [sme_pkg::WORD_W-1:0]     push_val;
    logic [sme_pkg::WORD_W-1:0]     pop_tos;
    logic                           fail;
    sme_pkg::err_t                  fail_err;

    always_comb
    begin
        d         = program_start ? '0 : depth_reg;
        left      = program_start ? '0 : left_reg;
        gat       = program_start ? '0 : gather_reg;
        third_eff = pend_reg ? ram_rdata : third_reg;
        full      = (d >= sme_pkg::DEPTH_W'(sme_pkg::STACK_DEPTH));
        shamt     = {2'(3'(sme_pkg::IMM_BYTES) - left), 3'b000};
        gat_new   = gat | (sme_pkg::WORD_W'(code_byte) << shamt);
        left_dec  = left - 1'b1;

        depth_next   = depth_reg;
        stopped_next = stopped_reg;
        left_next    = left_reg;
        gather_next  = gather_reg;
        tos_next     = tos_reg;
        nos_next     = nos_reg;
        third_next   = third_eff;
        pend_next    = 1'b0;

        do_push  = 1'b0;
        do_pop   = 1'b0;
        push_val = tos_reg;
        pop_tos  = nos_reg;
        fail     = 1'b0;
        fail_err = sme_pkg::ERR_NONE;

        res_valid = 1'b0;
        res.kind  = sme_pkg::KIND_PRINT;
        res.value = '0;
        res.err   = sme_pkg::ERR_NONE;

        if (accept && (program_start || !stopped_reg))
        begin
            stopped_next = 1'b0;
            depth_next   = d;
            left_next    = left;
            gather_next  = gat;
            if (left != '0)
            begin
                // immediate byte of a push, little-endian
                left_next   = left_dec;
                gather_next = gat_new;
                if (left_dec == '0)
                begin
                    if (full)
                    begin
                        fail     = 1'b1;
                        fail_err = sme_pkg::ERR_OVERFLOW;
                    end
                    else
                    begin
                        do_push  = 1'b1;
                        push_val = gat_new;
                        if (program_end)
                        begin
                            fail     = 1'b1;
                            fail_err = sme_pkg::ERR_PAST_END;
                        end
                    end
                end
                else if (program_end)
                begin
                    fail     = 1'b1;
                    fail_err = sme_pkg::ERR_SHORT_IMM;
                end
            end
            else
            begin
                unique case (sme_pkg::opcode_t'(code_byte)) inside
                    sme_pkg::OP_NOP:
                    begin
                        if (program_end)
                        begin
                            fail     = 1'b1;
                            fail_err = sme_pkg::ERR_PAST_END;
                        end
                    end
                    sme_pkg::OP_PUSH:
                    begin
                        if (program_end)
                        begin
                            fail     = 1'b1;
                            fail_err = sme_pkg::ERR_SHORT_IMM;
                        end
                        else
                        begin
                            left_next   = sme_pkg::IMM_LEFT_W'(sme_pkg::IMM_BYTES);
                            gather_next = '0;
                        end
                    end
                    sme_pkg::OP_DUP:
                    begin
                        if (d == '0)
                        begin
                            fail     = 1'b1;
                            fail_err = sme_pkg::ERR_UNDERFLOW;
                        end
                        else if (full)
                        begin
                            fail     = 1'b1;
                            fail_err = sme_pkg::ERR_OVERFLOW;
                        end
                        else
                        begin
                            do_push  = 1'b1;
                            push_val = tos_reg;
                            if (program_end)
                            begin
                                fail     = 1'b1;
                                fail_err = sme_pkg::ERR_PAST_END;
                            end
                        end
                    end
                    sme_pkg::OP_DROP, sme_pkg::OP_ADD, sme_pkg::OP_PRINT:
                    begin
                        if ((d == '0) || ((code_byte == sme_pkg::OP_ADD) &&
                            (d < sme_pkg::DEPTH_W'(2))))
                        begin
                            fail     = 1'b1;
                            fail_err = sme_pkg::ERR_UNDERFLOW;
                        end
                        else
                        begin
                            do_pop  = 1'b1;
                            pop_tos = (code_byte == sme_pkg::OP_ADD) ?
                                      (nos_reg + tos_reg) : nos_reg;
                            if (code_byte == sme_pkg::OP_PRINT)
                            begin
                                res.value = tos_reg;
                                if (!program_end)
                                begin
                                    res_valid = 1'b1;
                                end
                            end
                            if (program_end)
                            begin
                                fail     = 1'b1;
                                fail_err = sme_pkg::ERR_PAST_END;
                            end
                        end
                    end
                    sme_pkg::OP_SWAP:
                    begin
                        if (d < sme_pkg::DEPTH_W'(2))
                        begin
                            fail     = 1'b1;
                            fail_err = sme_pkg::ERR_UNDERFLOW;
                        end
                        else
                        begin
                            tos_next = nos_reg;
                            nos_next = tos_reg;
                            if (program_end)
                            begin
                                fail     = 1'b1;
                                fail_err = sme_pkg::ERR_PAST_END;
                            end
                        end
                    end
                    sme_pkg::OP_HALT:
                    begin
                        stopped_next = 1'b1;
                        res_valid    = 1'b1;
                        res.kind     = sme_pkg::KIND_HALT;
                    end
                    default:
                    begin
                        fail     = 1'b1;
                        fail_err = sme_pkg::ERR_UNKNOWN;
                    end
                endcase
            end

            if (do_push)
            begin
                // spill second entry to RAM, cache shifts down
                depth_next = d + 1'b1;
                tos_next   = push_val;
                nos_next   = tos_reg;
                third_next = nos_reg;
            end
            if (do_pop)
            begin
                // refill third entry from RAM, lands next cycle
                depth_next = d - 1'b1;
                tos_next   = pop_tos;
                nos_next   = third_eff;
                pend_next  = 1'b1;
            end
            if (fail)
            begin
                stopped_next = 1'b1;
                left_next    = '0;
                res_valid    = 1'b1;
                res.kind     = sme_pkg::KIND_ERROR;
                res.err      = fail_err;
                if (fail_err != sme_pkg::ERR_PAST_END)
                begin
                    res.value = '0;
                end
                else if (!(do_pop && (code_byte == sme_pkg::OP_PRINT)))
                begin
                    res.value = '0;
                end
            end
        end

        res.depth = sme_pkg::depth_field(depth_next);

        ram_req.wr_en   = do_push && (d >= sme_pkg::DEPTH_W'(2));
        ram_req.wr_addr = sme_pkg::ADDR_W'(d - sme_pkg::DEPTH_W'(2));
        ram_req.wr_data = nos_reg;
        ram_req.rd_en   = do_pop;
        ram_req.rd_addr = sme_pkg::ADDR_W'(d - sme_pkg::DEPTH_W'(4));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg   <= '0;
            stopped_reg <= 1'b1;
            left_reg    <= '0;
            gather_reg  <= '0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            depth_reg   <= depth_next;
            stopped_reg <= stopped_next;
            left_reg    <= left_next;
            gather_reg  <= gather_next;
            pend_reg    <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tos_reg   <= tos_next;
        nos_reg   <= nos_next;
        third_reg <= third_next;
    end

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= sme_pkg::DEPTH_W'(sme_pkg::STACK_DEPTH))
        else $error("stack depth beyond capacity");

    a_stop_no_imm: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |-> (left_reg == '0))
        else $error("pending immediate while stopped");

    a_stopped_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && stopped_reg && !program_start) |-> !res_valid)
        else $error("result while stopped");

    a_refill_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> $past(accept))
        else $error("RAM refill without a request");

endmodule

// File: src/sme_out_stage.sv
// ----------------------------------------------------------------------------
// sme_out_stage
// Output register between the executor and the result channel.
// ----------------------------------------------------------------------------
module sme_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_valid,
    input  sme_pkg::result_t res,
    output logic             take,
    sme_out_if.source        result
);

    logic             valid_reg;
    sme_pkg::result_t data_reg;

    assign take = !valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && res_valid)
        begin
            data_reg <= res;
        end
    end

    assign result.valid         = valid_reg;
    assign result.result_kind   = data_reg.kind;
    assign result.printed_value = data_reg.value;
    assign result.error_code    = data_reg.err;
    assign result.stack_depth   = data_reg.depth;

endmodule

// File: src/stack_machine_byte_executor_top.sv
// ----------------------------------------------------------------------------
// stack_machine_byte_executor_top
// Byte-serial stack machine: executes a program byte stream on a 32-bit stack.
// ----------------------------------------------------------------------------
// One instruction byte is accepted every clock cycle, sustained, whatever the
// opcode; a print, halt or error shows up in the output register on the cycle
// after its byte, and input keeps flowing while that result waits, stalling
// only when the output register is full and not being taken. The top three
// stack entries sit in registers; the rest live in one single-port-read RAM
// whose registered read refills the third entry after each pop, so the cache
// and that read port set the one-byte-per-cycle figure. No clearing pass is
// needed after reset: a program start resets depth and any partial immediate.
// ----------------------------------------------------------------------------
module stack_machine_byte_executor_top (
    input  logic      clk,
    input  logic      rst_n,
    sme_in_if.sink    instr,
    sme_out_if.source result
);

    logic                       take;
    logic                       accept;
    logic                       res_valid;
    sme_pkg::result_t           res;
    sme_pkg::ram_req_t          ram_req;
    logic [sme_pkg::WORD_W-1:0] ram_rdata;

    assign instr.ready = take;
    assign accept      = instr.valid && take;

    sme_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .code_byte     (instr.code_byte),
        .program_start (instr.program_start),
        .program_end   (instr.program_end),
        .ram_rdata     (ram_rdata),
        .ram_req       (ram_req),
        .res_valid     (res_valid),
        .res           (res)
    );

    sme_ram #(
        .WIDTH (sme_pkg::WORD_W),
        .DEPTH (sme_pkg::STACK_DEPTH)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (ram_req.wr_en),
        .wr_addr (ram_req.wr_addr),
        .wr_data (ram_req.wr_data),
        .rd_en   (ram_req.rd_en),
        .rd_addr (ram_req.rd_addr),
        .rd_data (ram_rdata)
    );

    sme_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .take      (take),
        .result    (result)
    );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the byte-serial stack machine executor. A queue of
// program bytes (directed programs, random well-formed programs, stack fills
// to the full depth, truncated programs and stray bytes) is fed through a
// bursty request driver. Every accepted byte runs through a local
// interpreter, and the results it predicts are matched in order against what
// the monitor sees on the stalling result channel.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CYCLE_LIMIT = 500000;
    localparam int END_WAIT    = 20;

    typedef struct {
        logic [7:0] code;
        bit         start;
        bit         last;
        bit         hold;   // wait for all pending results before sending
    } prog_byte_t;

    logic clk = 1'b0;
    logic rst_n;

    sme_in_if  instr_if ();
    sme_out_if result_if ();

    stack_machine_byte_executor_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .instr  (instr_if),
        .result (result_if)
    );

    always #6 clk = ~clk;

    prog_byte_t         byte_q[$];
    sme_pkg::result_t   expected_results[$];
    int                 errors      = 0;
    int                 cycle_count = 0;
    bit                 open_next   = 1'b0;
    bit                 hold_next   = 1'b0;

    // interpreter state
    logic [31:0] stack_mem [sme_pkg::STACK_DEPTH];
    int unsigned stack_ptr = 0;
    bit          stopped   = 1'b1;
    int unsigned imm_left  = 0;
    logic [31:0] imm_word  = '0;

    function automatic sme_pkg::result_t make_result(sme_pkg::kind_t k, logic [31:0] v,
                                                     sme_pkg::err_t e);
        sme_pkg::result_t r;
        r.kind  = k;
        r.value = v;
        r.err   = e;
        r.depth = 9'(stack_ptr);
        return r;
    endfunction

    function automatic sme_pkg::result_t stop_with(sme_pkg::err_t e, logic [31:0] v);
        stopped  = 1'b1;
        imm_left = 0;
        return make_result(sme_pkg::KIND_ERROR, v, e);
    endfunction

    // Executes one program byte; returns 1 when the byte produces a result.
    function automatic bit exec_byte(input logic [7:0] code, input bit start,
                                     input bit last, output sme_pkg::result_t r);
        logic [31:0] v;
        r = '0;
        if (start)
        begin
            stack_ptr = 0;
            stopped   = 1'b0;
            imm_left  = 0;
            imm_word  = '0;
        end
        else if (stopped)
            return 1'b0;

        if (imm_left != 0)
        begin
            imm_word |= {24'd0, code} << (8 * (sme_pkg::IMM_BYTES - imm_left));
            imm_left--;
            if (imm_left == 0)
            begin
                // overflow is only known once the whole word is in
                if (stack_ptr >= sme_pkg::STACK_DEPTH)
                begin
                    r = stop_with(sme_pkg::ERR_OVERFLOW, '0);
                    return 1'b1;
                end
                stack_mem[stack_ptr] = imm_word;
                stack_ptr++;
                if (last)
                begin
                    r = stop_with(sme_pkg::ERR_PAST_END, '0);
                    return 1'b1;
                end
                return 1'b0;
            end
            if (last)
            begin
                r = stop_with(sme_pkg::ERR_SHORT_IMM, '0);
                return 1'b1;
            end
            return 1'b0;
        end

        case (code)
            sme_pkg::OP_NOP: ;
            sme_pkg::OP_PUSH:
            begin
                if (last)
                begin
                    r = stop_with(sme_pkg::ERR_SHORT_IMM, '0);
                    return 1'b1;
                end
                imm_left = sme_pkg::IMM_BYTES;
                imm_word = '0;
                return 1'b0;
            end
            sme_pkg::OP_DUP:
            begin
                if (stack_ptr < 1)
                begin
                    r = stop_with(sme_pkg::ERR_UNDERFLOW, '0);
                    return 1'b1;
                end
                if (stack_ptr >= sme_pkg::STACK_DEPTH)
                begin
                    r = stop_with(sme_pkg::ERR_OVERFLOW, '0);
                    return 1'b1;
                end
                stack_mem[stack_ptr] = stack_mem[stack_ptr - 1];
                stack_ptr++;
            end
            sme_pkg::OP_DROP:
            begin
                if (stack_ptr < 1)
                begin
                    r = stop_with(sme_pkg::ERR_UNDERFLOW, '0);
                    return 1'b1;
                end
                stack_ptr--;
            end
            sme_pkg::OP_SWAP:
            begin
                if (stack_ptr < 2)
                begin
                    r = stop_with(sme_pkg::ERR_UNDERFLOW, '0);
                    return 1'b1;
                end
                v = stack_mem[stack_ptr - 1];
                stack_mem[stack_ptr - 1] = stack_mem[stack_ptr - 2];
                stack_mem[stack_ptr - 2] = v;
            end
            sme_pkg::OP_ADD:
            begin
                if (stack_ptr < 2)
                begin
                    r = stop_with(sme_pkg::ERR_UNDERFLOW, '0);
                    return 1'b1;
                end
                stack_mem[stack_ptr - 2] = stack_mem[stack_ptr - 2] + stack_mem[stack_ptr - 1];
                stack_ptr--;
            end
            sme_pkg::OP_PRINT:
            begin
                if (stack_ptr < 1)
                begin
                    r = stop_with(sme_pkg::ERR_UNDERFLOW, '0);
                    return 1'b1;
                end
                v = stack_mem[stack_ptr - 1];
                stack_ptr--;
                // a print on the final byte folds into the past-end error
                if (last)
                    r = stop_with(sme_pkg::ERR_PAST_END, v);
                else
                    r = make_result(sme_pkg::KIND_PRINT, v, sme_pkg::ERR_NONE);
                return 1'b1;
            end
            sme_pkg::OP_HALT:
            begin
                stopped = 1'b1;
                r = make_result(sme_pkg::KIND_HALT, '0, sme_pkg::ERR_NONE);
                return 1'b1;
            end
            default:
            begin
                r = stop_with(sme_pkg::ERR_UNKNOWN, '0);
                return 1'b1;
            end
        endcase

        if (last)
        begin
            r = stop_with(sme_pkg::ERR_PAST_END, '0);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // program generation
    // ------------------------------------------------------------------
    task automatic put(input logic [7:0] code, input bit last);
        prog_byte_t it;
        it.code   = code;
        it.start  = open_next;
        it.last   = last;
        it.hold   = hold_next;
        open_next = 1'b0;
        hold_next = 1'b0;
        byte_q.push_back(it);
    endtask

    // little-endian immediate; last flag goes on the final byte sent
    task automatic put_word(input logic [31:0] w, input int nbytes, input bit last);
        for (int i = 0; i < nbytes; i++)
            put(w[8*i +: 8], last && (i == nbytes - 1));
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    task automatic gen_program();
        int          d;
        int          n;
        int          pick;
        int          k;
        logic [7:0]  op;
        d = 0;
        n = $urandom_range(0, 14);
        open_next = 1'b1;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
            begin
                // opcode with no regard for depth: may underflow or be unknown
                op = 8'($urandom_range(0, 9));
                if (op == sme_pkg::OP_PUSH)
                    op = sme_pkg::OP_DROP;
                put(op, 1'b0);
            end
            else if (pick == 1 && $urandom_range(0, 3) == 0)
                put(sme_pkg::OP_HALT, 1'b0);  // early halt; the rest is ignored
            else if (pick <= 6 || d == 0)
            begin
                put(sme_pkg::OP_PUSH, 1'b0);
                if ($urandom_range(0, 29) == 0)
                begin
                    // cut short; next program start drops the push
                    put_word(rand_word(), $urandom_range(0, 3), 1'b0);
                    return;
                end
                put_word(rand_word(), sme_pkg::IMM_BYTES, 1'b0);
                d++;
            end
            else
            begin
                case ($urandom_range(0, 5))
                    0: put(sme_pkg::OP_NOP, 1'b0);
                    1:
                    begin
                        put(sme_pkg::OP_DUP, 1'b0);
                        d++;
                    end
                    2:
                    begin
                        put(sme_pkg::OP_DROP, 1'b0);
                        d--;
                    end
                    3: put((d >= 2) ? sme_pkg::OP_SWAP : sme_pkg::OP_NOP, 1'b0);
                    4:
                    begin
                        if (d >= 2)
                        begin
                            put(sme_pkg::OP_ADD, 1'b0);
                            d--;
                        end
                        else
                            put(sme_pkg::OP_NOP, 1'b0);
                    end
                    default:
                    begin
                        put(sme_pkg::OP_PRINT, 1'b0);
                        d--;
                    end
                endcase
            end
        end

        if ($urandom_range(0, 11) == 0)
            return;  // no end flag at all

        case ($urandom_range(0, 9))
            5: put(sme_pkg::OP_PRINT, 1'b1);
            6:
            begin
                op = 8'($urandom_range(0, 5));
                if (op == sme_pkg::OP_PUSH)
                    op = sme_pkg::OP_NOP;
                put(op, 1'b1);
            end
            7:
            begin
                k = $urandom_range(0, sme_pkg::IMM_BYTES);
                put(sme_pkg::OP_PUSH, k == 0);
                put_word(rand_word(), k, 1'b1);
            end
            8: put(8'($urandom_range(8, 255)), 1'b1);
            default: put(sme_pkg::OP_HALT, 1'b1);
        endcase
    endtask

    // Fills the stack to its full depth, then overflows it.
    task automatic gen_fill(input bit via_push);
        open_next = 1'b1;
        put(sme_pkg::OP_PUSH, 1'b0);
        put_word(rand_word(), sme_pkg::IMM_BYTES, 1'b0);
        if (!via_push)
        begin
            for (int i = 1; i < sme_pkg::STACK_DEPTH; i++)
                put(sme_pkg::OP_DUP, 1'b0);
            put(sme_pkg::OP_DUP, 1'b1);
        end
        else
        begin
            for (int i = 1; i < sme_pkg::STACK_DEPTH - 1; i++)
                put(sme_pkg::OP_DUP, 1'b0);
            put(sme_pkg::OP_PUSH, 1'b0);
            put_word(rand_word(), sme_pkg::IMM_BYTES, 1'b0);
            // pop from the full stack and refill before the final push
            put(sme_pkg::OP_PRINT, 1'b0);
            put(sme_pkg::OP_SWAP, 1'b0);
            put(sme_pkg::OP_PRINT, 1'b0);
            put(sme_pkg::OP_DUP, 1'b0);
            put(sme_pkg::OP_DUP, 1'b0);
            put(sme_pkg::OP_PUSH, 1'b0);
            put_word(rand_word(), sme_pkg::IMM_BYTES, 1'b1);
        end
    endtask

    // ------------------------------------------------------------------
    // request driver: bursts with random gaps
    // ------------------------------------------------------------------
    int burst_left = 8;
    int gap_left   = 0;

    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        sme_pkg::result_t r;
        bit               took;
        if (!rst_n)
        begin
            instr_if.valid         <= 1'b0;
            instr_if.code_byte     <= '0;
            instr_if.program_start <= 1'b0;
            instr_if.program_end   <= 1'b0;
        end
        else
        begin
            took = instr_if.valid && instr_if.ready;
            if (took)
            begin
                if (exec_byte(instr_if.code_byte, instr_if.program_start,
                              instr_if.program_end, r))
                    expected_results.push_back(r);
                void'(byte_q.pop_front());
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                end
            end
            if (!instr_if.valid || took)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    instr_if.valid <= 1'b0;
                end
                else if (byte_q.size() == 0)
                    instr_if.valid <= 1'b0;
                else if (byte_q[0].hold && expected_results.size() != 0)
                    instr_if.valid <= 1'b0;
                else
                begin
                    instr_if.valid         <= 1'b1;
                    instr_if.code_byte     <= byte_q[0].code;
                    instr_if.program_start <= byte_q[0].start;
                    instr_if.program_end   <= byte_q[0].last;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor with a rotating stall pattern
    // ------------------------------------------------------------------
    logic [15:0] stall_pat;
    logic [3:0]  stall_phase;

    always @(posedge clk or negedge rst_n)
    begin : monitor_proc
        sme_pkg::result_t want;
        if (!rst_n)
        begin
            result_if.ready <= 1'b0;
            stall_pat       <= 16'hFFFF;
            stall_phase     <= '0;
        end
        else
        begin
            if (result_if.valid && result_if.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result kind=%0d value=%0d err=%0d depth=%0d",
                             $time, result_if.result_kind, result_if.printed_value,
                             result_if.error_code, result_if.stack_depth);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result_if.result_kind !== want.kind
                        || result_if.printed_value !== want.value
                        || result_if.error_code !== want.err
                        || result_if.stack_depth !== want.depth)
                    begin
                        $display("%0t: mismatch: expected kind=%0d value=%0d err=%0d depth=%0d",
                                 $time, want.kind, want.value, want.err, want.depth);
                        $display("%0t:           actual   kind=%0d value=%0d err=%0d depth=%0d",
                                 $time, result_if.result_kind, result_if.printed_value,
                                 result_if.error_code, result_if.stack_depth);
                        errors++;
                    end
                end
            end
            result_if.ready <= stall_pat[stall_phase];
            stall_phase     <= stall_phase + 4'd1;
            if (stall_phase == 4'hF)
            begin
                case ($urandom_range(0, 2))
                    0:       stall_pat <= 16'hFFFF;
                    1:       stall_pat <= 16'($urandom()) | 16'h0001;
                    default: stall_pat <= 16'($urandom() & $urandom()) | 16'h0001;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin : stim_proc
        int prog_idx;
        rst_n = 1'b0;

        // stray bytes before any program start are ignored
        put(sme_pkg::OP_HALT, 1'b0);
        put(8'hFF, 1'b1);

        // every opcode; add wraps to the most negative word
        open_next = 1'b1;
        put(sme_pkg::OP_NOP, 1'b0);
        put(sme_pkg::OP_PUSH, 1'b0);
        put_word(32'h7FFF_FFFF, sme_pkg::IMM_BYTES, 1'b0);
        put(sme_pkg::OP_PUSH, 1'b0);
        put_word(32'h0000_0001, sme_pkg::IMM_BYTES, 1'b0);
        put(sme_pkg::OP_ADD, 1'b0);
        put(sme_pkg::OP_DUP, 1'b0);
        put(sme_pkg::OP_SWAP, 1'b0);
        put(sme_pkg::OP_DROP, 1'b0);
        put(sme_pkg::OP_PRINT, 1'b0);
        put(sme_pkg::OP_HALT, 1'b1);

        // print on empty stack, start and end on one byte
        hold_next = 1'b1;
        open_next = 1'b1;
        put(sme_pkg::OP_PRINT, 1'b1);

        // print as the final byte
        open_next = 1'b1;
        put(sme_pkg::OP_PUSH, 1'b0);
        put_word(32'h8000_0000, sme_pkg::IMM_BYTES, 1'b0);
        put(sme_pkg::OP_PRINT, 1'b1);

        open_next = 1'b1;
        put(8'hA5, 1'b0);

        open_next = 1'b1;
        put(sme_pkg::OP_PUSH, 1'b1);

        prog_idx = 0;
        while (byte_q.size() < 800)
        begin
            if (prog_idx == 3)
                gen_fill(1'b0);
            else if (prog_idx == 8)
                gen_fill(1'b1);
            else
                gen_program();
            if (prog_idx == 12)
                hold_next = 1'b1;
            if ($urandom_range(0, 3) == 0)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    open_next = ($urandom_range(0, 7) == 0);
                    put(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
                end
            end
            prog_idx++;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (byte_q.size() != 0 || instr_if.valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (END_WAIT) @(posedge clk);

        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
